>>> src/aptla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptla_pkg
// Shared constants and types for the access point learning table.
// ----------------------------------------------------------------------------
package aptla_pkg;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_UPDATED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_SWEPT    = 2'd3;

    localparam logic [1:0] CLS_OPEN = 2'd0;
    localparam logic [1:0] CLS_WEP  = 2'd1;
    localparam logic [1:0] CLS_WPA  = 2'd2;

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_WPA_MASK = 2'd1;
    localparam logic [1:0] REG_WEP_MASK = 2'd2;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_SWEEP   = 1'b1;

    // One table row as held in the row memory.
    // slot is sized for the largest supported table (4096 rows).
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] stamp;
        logic [7:0]  channel;
        logic [7:0]  signal;
        logic [15:0] flag_word;
        logic [1:0]  cls;
        logic [11:0] slot;
    } row_t;

endpackage
`default_nettype wire

>>> src/ap_table_learn_and_age_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ap_table_learn_and_age_core
// Access point learning table with aging, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (tdata low bit up)
// s_axis   in   tdata: station_mac, radio_channel, signal_level, ap_flags,
//               now_ms ; tuser: opcode
// m_axis   out  tdata: status, ap_class, class_slot, removed_count,
//               total_entries
// cfg      in   index, wdata (0 timeout_ms, 1 wpa mask, 2 wep mask)
//
// Every item walks all TABLE_ENTRIES rows through one memory port, one row per
// cycle; an observe that inserts then searches one class bitmap for a free
// slot, one bit per cycle.
// Reset clears valid bits, slot bitmaps, count and configuration registers at once.
// The result sits in an output register; the next item is taken after it
// has been delivered.
// ----------------------------------------------------------------------------
module ap_table_learn_and_age_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [111:0] s_axis_tdata,  // mac, channel, signal, flags, now_ms
    input  wire logic         s_axis_tuser,  // opcode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // status, ap_class, class_slot,
                                             // removed_count, total_entries
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SLOT, S_WRITE, S_DONE
    } state_t;

    state_t            state_reg;
    logic [31:0]       timeout_reg;
    logic [15:0]       wpa_reg, wep_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] used_reg [3];
    logic [CW-1:0]     count_reg;
    logic              op_reg;
    logic [47:0]       mac_reg;
    logic [7:0]        chan_reg, sig_reg;
    logic [15:0]       flags_reg;
    logic [31:0]       now_reg;
    logic [AW-1:0]     addr_reg;       // memory address being issued
    logic [CW-1:0]     idx_reg;        // general counter
    logic              rd_ok_reg;      // memory data valid this cycle
    logic [AW-1:0]     rd_row_reg;     // row of that data
    logic              hit_reg;
    logic [AW-1:0]     hit_row_reg;
    logic              free_found_reg;
    logic [AW-1:0]     free_row_reg;
    logic [AW-1:0]     slot_reg;
    logic [1:0]        cls_reg;
    logic [CW-1:0]     removed_reg;
    logic [31:0]       out_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    aptla_pkg::row_t   mem_wdata, mem_rdata;
    logic [31:0]       elapsed;
    logic [1:0]        cls_new;

    aptla_row_mem #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_DONE);
    assign m_axis_tdata  = out_reg;
    assign elapsed       = now_reg - mem_rdata.stamp;
    assign cls_new = ((flags_reg & wpa_reg) != 16'd0) ? aptla_pkg::CLS_WPA :
                     ((flags_reg & wep_reg) != 16'd0) ? aptla_pkg::CLS_WEP :
                     aptla_pkg::CLS_OPEN;

    // Write-back: update on hit, new row on insert.
    // On a hit cls_reg/slot_reg hold the class and slot read from that row.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = mem_rdata;
        if (state_reg == S_WRITE)
        begin
            mem_we              = 1'b1;
            mem_addr            = hit_reg ? hit_row_reg : free_row_reg;
            mem_wdata.mac       = mac_reg;
            mem_wdata.stamp     = now_reg;
            mem_wdata.channel   = chan_reg;
            mem_wdata.signal    = sig_reg;
            mem_wdata.flag_word = flags_reg;
            mem_wdata.cls       = cls_reg;
            mem_wdata.slot      = 12'(slot_reg);
        end
    end

    // Output word packing.
    function automatic logic [31:0] pack(input logic [1:0] st, input logic [1:0] c,
                                         input logic [7:0] s, input logic [8:0] r,
                                         input logic [8:0] t);
        pack = {2'b00, t, r, s, c, st};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            timeout_reg <= '0;
            wpa_reg     <= '0;
            wep_reg     <= '0;
            valid_reg   <= '0;
            used_reg[0] <= '0;
            used_reg[1] <= '0;
            used_reg[2] <= '0;
            count_reg   <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            aptla_pkg::REG_TIMEOUT:  timeout_reg <= cfg_wdata;
                            aptla_pkg::REG_WPA_MASK: wpa_reg <= cfg_wdata[15:0];
                            aptla_pkg::REG_WEP_MASK: wep_reg <= cfg_wdata[15:0];
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= s_axis_tuser;
                        mac_reg   <= s_axis_tdata[47:0];
                        chan_reg  <= s_axis_tdata[55:48];
                        sig_reg   <= s_axis_tdata[63:56];
                        flags_reg <= s_axis_tdata[79:64];
                        now_reg   <= s_axis_tdata[111:80];
                        addr_reg  <= '0;
                        idx_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        free_found_reg <= 1'b0;
                        removed_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // issue reads for rows 0..N-1; the registered read data follows
                    if (idx_reg < CW'(TABLE_ENTRIES))
                    begin
                        addr_reg  <= addr_reg + AW'(1);
                        idx_reg   <= idx_reg + CW'(1);
                        rd_ok_reg <= 1'b1;
                        rd_row_reg <= addr_reg;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                    end
                    if (rd_ok_reg)
                    begin
                        if (op_reg == aptla_pkg::OP_SWEEP)
                        begin
                            if (valid_reg[rd_row_reg] && timeout_reg != 32'd0
                                && elapsed > timeout_reg)
                            begin
                                valid_reg[rd_row_reg] <= 1'b0;
                                if (mem_rdata.cls != 2'd3)
                                    used_reg[mem_rdata.cls][mem_rdata.slot[AW-1:0]] <= 1'b0;
                                removed_reg <= removed_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            if (!hit_reg && valid_reg[rd_row_reg]
                                && mem_rdata.mac == mac_reg)
                            begin
                                hit_reg     <= 1'b1;
                                hit_row_reg <= rd_row_reg;
                                cls_reg     <= mem_rdata.cls;
                                slot_reg    <= mem_rdata.slot[AW-1:0];
                            end
                            if (!free_found_reg && !valid_reg[rd_row_reg])
                            begin
                                free_found_reg <= 1'b1;
                                free_row_reg   <= rd_row_reg;
                            end
                        end
                    end
                    if (!rd_ok_reg && idx_reg == CW'(TABLE_ENTRIES))
                    begin
                        idx_reg <= '0;
                        if (op_reg == aptla_pkg::OP_SWEEP)
                        begin
                            count_reg <= count_reg - removed_reg;
                            out_reg <= pack(aptla_pkg::ST_SWEPT, 2'd0, 8'd0,
                                            9'(removed_reg), 9'(count_reg - removed_reg));
                            state_reg <= S_DONE;
                        end
                        else if (hit_reg)
                        begin
                            out_reg <= pack(aptla_pkg::ST_UPDATED, cls_reg, 8'(slot_reg),
                                            9'd0, 9'(count_reg));
                            state_reg <= S_WRITE;
                        end
                        else if (!free_found_reg)
                        begin
                            out_reg <= pack(aptla_pkg::ST_FULL, cls_new, 8'd0,
                                            9'd0, 9'(count_reg));
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cls_reg   <= cls_new;
                            state_reg <= S_SLOT;
                        end
                    end
                end
                S_SLOT:
                begin
                    // lowest free slot of the class, one bit per cycle
                    if (!used_reg[cls_reg][idx_reg[AW-1:0]])
                    begin
                        slot_reg <= idx_reg[AW-1:0];
                        out_reg  <= pack(aptla_pkg::ST_INSERTED, cls_reg,
                                         8'(idx_reg[AW-1:0]), 9'd0,
                                         9'(count_reg + CW'(1)));
                        state_reg <= S_WRITE;
                    end
                    else if (idx_reg == CW'(TABLE_ENTRIES - 1))
                    begin
                        out_reg <= pack(aptla_pkg::ST_FULL, cls_reg, 8'd0, 9'd0,
                                        9'(count_reg));
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_WRITE:
                begin
                    if (!hit_reg)
                    begin
                        valid_reg[free_row_reg]      <= 1'b1;
                        used_reg[cls_reg][slot_reg]  <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/aptla_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptla_row_mem
// Single port row memory, registered read.
// ----------------------------------------------------------------------------
module aptla_row_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire aptla_pkg::row_t  wdata,
    output aptla_pkg::row_t       rdata
);
    aptla_pkg::row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
